// ===== src/swdhte_pkg.sv =====
// Shared types and constants for the SWD host transaction engine.
// No dependencies; used by every module of the block.
package swdhte_pkg;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_READ    = 2'd1,
		ACT_WRITE   = 2'd2,
		ACT_CONNECT = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_WAIT    = 3'd1,
		ST_FAULT   = 3'd2,
		ST_PARITY  = 3'd3,
		ST_OTHER   = 3'd4
	} status_t;

	localparam logic [2:0] ACK_OK    = 3'b001;
	localparam logic [2:0] ACK_STALL = 3'b010;
	localparam logic [2:0] ACK_FAULT = 3'b100;

	localparam logic [15:0] JTAG_TO_SWD  = 16'hE79E;
	localparam logic [7:0]  CONNECT_BITS = 8'd152;
	localparam logic [7:0]  CONN_ONES_A  = 8'd64;
	localparam logic [7:0]  CONN_SEQ_END = 8'd80;
	localparam logic [7:0]  CONN_ONES_B  = 8'd144;
	localparam logic [7:0]  HDR_BITS     = 8'd8;
	localparam logic [7:0]  ACK_LEN      = 8'd3;
	localparam logic [7:0]  DATA_BITS    = 8'd32;

	// Register map: word index taken from paddr[2]
	localparam logic       REG_WAIT_RETRIES = 1'b0;
	localparam logic [3:0] WAIT_RETRIES_RST = 4'd4;

	typedef struct packed {
		action_t     action;
		logic        ap_not_dp;
		logic [1:0]  reg_addr;
		logic [31:0] write_data;
		logic        swdio_in;
	} item_t;

	typedef struct packed {
		logic        swdio_out;
		logic        swdio_oe;
		logic        done_res;
		status_t     status;
		logic [2:0]  ack_bits;
		logic [31:0] read_data;
	} result_t;

endpackage

// ===== src/swd_host_transaction_engine_core.sv =====
// SWD host transaction engine: top level with input register, bit engine and
// result register. Depends on swdhte_pkg, swdhte_apb_regs and swdhte_bit_engine.

// Each input transfer is one SWCLK bit period (tick) or a request (read, write,
// connect). The engine takes one transfer per clock unless stalled: a transfer
// is captured in the input register, then the bit engine updates its phase and
// shift registers from it and loads the result register, from which a tick's
// result is offered. The rate is set by the engine's state loop, which advances
// one bit per cycle while not stalled. Requests and idle ticks give no result;
// the input side stalls only while the result register holds a result that the
// sink has not taken. wait_retries is written over APB at word index 0 (paddr[2] clear).
module swd_host_transaction_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: ap_not_dp[0], reg_addr[2:1], write_data[34:3], swdio_in[35], zero[39:36]
	input  logic [39:0] s_tdata,
	// tuser: action[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: swdio_out[0], swdio_oe[1], ack_bits[4:2], read_data[36:5], zero[39:37]
	output logic [39:0] m_tdata,
	// tuser: status[2:0]
	output logic [2:0]  m_tuser,
	// tlast: done_res
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	swdhte_pkg::item_t   item_in, item_s1;
	swdhte_pkg::result_t eng_res, res_q;
	logic                valid_s1;
	logic                m_tvalid_q;
	logic                out_free;
	logic                step_en;
	logic                eng_valid;
	logic [3:0]          wait_retries;

	assign item_in.action     = swdhte_pkg::action_t'(s_tuser);
	assign item_in.ap_not_dp  = s_tdata[0];
	assign item_in.reg_addr   = s_tdata[2:1];
	assign item_in.write_data = s_tdata[34:3];
	assign item_in.swdio_in   = s_tdata[35];

	assign out_free = !m_tvalid_q || m_tready;
	assign step_en  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	swdhte_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.wait_retries (wait_retries)
	);

	swdhte_bit_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (step_en),
		.item         (item_s1),
		.wait_retries (wait_retries),
		.res_valid    (eng_valid),
		.res          (eng_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	// result register: load on a producing step, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= step_en && eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && eng_valid) begin
			res_q <= eng_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = res_q.done_res;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {3'b000, res_q.read_data, res_q.ack_bits, res_q.swdio_oe,
		res_q.swdio_out};

`ifndef SYNTHESIS
	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted transfer not held in input register");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled transfer");

	a_released_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> !m_tdata[0])
		else $error("swdio_out high while line released");

	a_fields_zero_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == 3'd0 && m_tdata[36:2] == 35'd0)
		else $error("status or data fields set outside done");
`endif

endmodule

// ===== src/swdhte_apb_regs.sv =====
// APB configuration register for the SWD host engine (wait_retries).
// Depends on swdhte_pkg for the register map and reset value.
module swdhte_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  wait_retries
);

	logic [3:0] wait_retries_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_retries_q <= swdhte_pkg::WAIT_RETRIES_RST;
		end else if (wr_en && paddr[2] == swdhte_pkg::REG_WAIT_RETRIES) begin
			wait_retries_q <= pwdata[3:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == swdhte_pkg::REG_WAIT_RETRIES) begin
			prdata = {28'd0, wait_retries_q};
		end
	end

	assign wait_retries = wait_retries_q;

endmodule

// ===== src/swdhte_bit_engine.sv =====
// SWD bit engine: phase sequencer, shift registers and per-tick result logic.
// Depends on swdhte_pkg for item/result types, ACK and status codes.
module swdhte_bit_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  swdhte_pkg::item_t   item,
	input  logic [3:0]          wait_retries,
	output logic                res_valid,
	output swdhte_pkg::result_t res
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_CONN      = 4'd1,
		PH_HDR       = 4'd2,
		PH_TRN_A     = 4'd3,
		PH_ACK       = 4'd4,
		PH_TRN_RETRY = 4'd5,
		PH_TRN_FAIL  = 4'd6,
		PH_TRN_W     = 4'd7,
		PH_WDATA     = 4'd8,
		PH_WPAR      = 4'd9,
		PH_RDATA     = 4'd10,
		PH_RPAR      = 4'd11,
		PH_TRN_R     = 4'd12
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  bit_count_q, bit_count_d, bc_inc;
	logic [31:0] shift_word_q, shift_word_d;
	logic [31:0] held_wr_q, held_wr_d;
	logic [3:0]  held_req_q, held_req_d;
	logic [2:0]  ack_shift_q, ack_shift_d, ack_next;
	logic [3:0]  attempt_q, attempt_d;
	logic        parity_q, parity_d;
	logic [7:0]  hdr;
	logic        din;

	assign din    = item.swdio_in;
	assign bc_inc = bit_count_q + 8'd1;
	assign ack_next = ack_shift_q | (3'(din) << bit_count_q[1:0]);

	// held_req: bit0 APnDP, bit1 A2, bit2 A3, bit3 RnW
	assign hdr = {1'b1, 1'b0,
		held_req_q[0] ^ held_req_q[3] ^ held_req_q[1] ^ held_req_q[2],
		held_req_q[2], held_req_q[1], held_req_q[3], held_req_q[0], 1'b1};

	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_word_d = shift_word_q;
		held_wr_d    = held_wr_q;
		held_req_d   = held_req_q;
		ack_shift_d  = ack_shift_q;
		attempt_d    = attempt_q;
		parity_d     = parity_q;
		res          = '0;
		res.status   = swdhte_pkg::ST_OK;
		res_valid    = 1'b0;

		if (item.action != swdhte_pkg::ACT_TICK) begin
			// requests load only an idle engine and never give a result
			if (phase_q == PH_IDLE) begin
				bit_count_d  = '0;
				shift_word_d = '0;
				ack_shift_d  = '0;
				attempt_d    = '0;
				parity_d     = 1'b0;
				if (item.action == swdhte_pkg::ACT_CONNECT) begin
					phase_d   = PH_CONN;
					held_wr_d = '0;
				end else begin
					phase_d    = PH_HDR;
					held_req_d = {item.action == swdhte_pkg::ACT_READ,
						item.reg_addr, item.ap_not_dp};
					held_wr_d  = (item.action == swdhte_pkg::ACT_WRITE) ?
						item.write_data : '0;
				end
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_CONN: begin
					res_valid    = 1'b1;
					res.swdio_oe = 1'b1;
					if (bit_count_q < swdhte_pkg::CONN_ONES_A) begin
						res.swdio_out = 1'b1;
					end else if (bit_count_q < swdhte_pkg::CONN_SEQ_END) begin
						res.swdio_out = swdhte_pkg::JTAG_TO_SWD[bit_count_q[3:0]];
					end else if (bit_count_q < swdhte_pkg::CONN_ONES_B) begin
						res.swdio_out = 1'b1;
					end else begin
						res.swdio_out = 1'b0;
					end
					bit_count_d = bc_inc;
					if (bc_inc >= swdhte_pkg::CONNECT_BITS) begin
						res.done_res = 1'b1;
						phase_d      = PH_IDLE;
						bit_count_d  = '0;
					end
				end
				PH_HDR: begin
					res_valid     = 1'b1;
					res.swdio_oe  = 1'b1;
					res.swdio_out = hdr[bit_count_q[2:0]];
					bit_count_d   = bc_inc;
					if (bc_inc >= swdhte_pkg::HDR_BITS) begin
						phase_d     = PH_TRN_A;
						bit_count_d = '0;
					end
				end
				PH_TRN_A: begin
					res_valid   = 1'b1;
					ack_shift_d = '0;
					phase_d     = PH_ACK;
					bit_count_d = '0;
				end
				PH_ACK: begin
					res_valid   = 1'b1;
					ack_shift_d = ack_next;
					bit_count_d = bc_inc;
					if (bc_inc >= swdhte_pkg::ACK_LEN) begin
						bit_count_d = '0;
						if (ack_next == swdhte_pkg::ACK_STALL && attempt_q < wait_retries) begin
							phase_d = PH_TRN_RETRY;
						end else if (ack_next != swdhte_pkg::ACK_OK) begin
							phase_d = PH_TRN_FAIL;
						end else if (held_req_q[3]) begin
							phase_d      = PH_RDATA;
							shift_word_d = '0;
							parity_d     = 1'b0;
						end else begin
							phase_d = PH_TRN_W;
						end
					end
				end
				PH_TRN_RETRY: begin
					res_valid   = 1'b1;
					attempt_d   = attempt_q + 4'd1;
					phase_d     = PH_HDR;
					bit_count_d = '0;
				end
				PH_TRN_FAIL: begin
					res_valid    = 1'b1;
					res.done_res = 1'b1;
					res.ack_bits = ack_shift_q;
					if (ack_shift_q == swdhte_pkg::ACK_STALL) begin
						res.status = swdhte_pkg::ST_WAIT;
					end else if (ack_shift_q == swdhte_pkg::ACK_FAULT) begin
						res.status = swdhte_pkg::ST_FAULT;
					end else begin
						res.status = swdhte_pkg::ST_OTHER;
					end
					phase_d = PH_IDLE;
				end
				PH_TRN_W: begin
					res_valid   = 1'b1;
					phase_d     = PH_WDATA;
					bit_count_d = '0;
				end
				PH_WDATA: begin
					res_valid     = 1'b1;
					res.swdio_oe  = 1'b1;
					res.swdio_out = held_wr_q[bit_count_q[4:0]];
					bit_count_d   = bc_inc;
					if (bc_inc >= swdhte_pkg::DATA_BITS) begin
						phase_d     = PH_WPAR;
						bit_count_d = '0;
					end
				end
				PH_WPAR: begin
					res_valid     = 1'b1;
					res.swdio_oe  = 1'b1;
					res.swdio_out = ^held_wr_q;
					res.done_res  = 1'b1;
					res.ack_bits  = ack_shift_q;
					phase_d       = PH_IDLE;
				end
				PH_RDATA: begin
					res_valid    = 1'b1;
					shift_word_d = {din, shift_word_q[31:1]};
					parity_d     = parity_q ^ din;
					bit_count_d  = bc_inc;
					if (bc_inc >= swdhte_pkg::DATA_BITS) begin
						phase_d     = PH_RPAR;
						bit_count_d = '0;
					end
				end
				PH_RPAR: begin
					res_valid = 1'b1;
					parity_d  = parity_q ^ din;
					phase_d   = PH_TRN_R;
				end
				PH_TRN_R: begin
					res_valid     = 1'b1;
					res.done_res  = 1'b1;
					res.ack_bits  = ack_shift_q;
					res.status    = parity_q ? swdhte_pkg::ST_PARITY : swdhte_pkg::ST_OK;
					res.read_data = shift_word_q;
					phase_d       = PH_IDLE;
				end
				default: begin
					phase_d     = PH_IDLE;
					bit_count_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			shift_word_q <= '0;
			held_wr_q    <= '0;
			held_req_q   <= '0;
			ack_shift_q  <= '0;
			attempt_q    <= '0;
			parity_q     <= 1'b0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_word_q <= shift_word_d;
			held_wr_q    <= held_wr_d;
			held_req_q   <= held_req_d;
			ack_shift_q  <= ack_shift_d;
			attempt_q    <= attempt_d;
			parity_q     <= parity_d;
		end
	end

endmodule
